// ===== sv/fctt_pkg.sv =====
// Package for the four-channel thermostat timer.
// Holds the transaction structs, request and action codes and the fixed limits.
// Has no dependencies; every module of the block imports it.
`default_nettype none

package fctt_pkg;

    localparam int FCTT_CHANNELS = 4;
    localparam int MAX_CHANNELS = 16;
    localparam int REPORT_CHANNELS = 4;

    localparam logic [7:0] RUN_LIMIT = 8'd10;
    localparam logic [1:0] ALARM_ON_RUN = 2'd2;
    localparam logic [2:0] ALARM_OFF_RUN = 3'd5;
    localparam logic [7:0] ALARM_THRESHOLD_RESET = 8'd40;

    localparam logic [2:0] REQ_SAMPLE = 3'd0;
    localparam logic [2:0] REQ_TICK = 3'd1;
    localparam logic [2:0] REQ_SET_TIMER = 3'd2;
    localparam logic [2:0] REQ_SET_THERMO = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_OFF = 2'd1;
    localparam logic [1:0] ACT_ON = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  channel;
        logic [7:0]  temp_whole;
        logic [6:0]  temp_hundredths;
        logic [15:0] minutes;
        logic [1:0]  action;
        logic [7:0]  threshold;
    } fctt_in_t;

    typedef struct packed {
        logic [3:0] relay_mask;
        logic       alarm_active;
        logic [3:0] timer_pending_mask;
    } fctt_out_t;

endpackage

`default_nettype wire

// ===== sv/four_channel_thermostat_timer.sv =====
// Top level of the four-channel thermostat timer with over-temperature alarm.
// Holds the input register, the per-channel state and the result register.
// Depends on fctt_pkg for the transaction structs and codes.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   fctt_in_t in_data
// out       output     out_valid/out_stall fctt_out_t out_data
// cfg       input      cfg_valid/cfg_ready alarm threshold cfg_data
//
// Each transaction is held in the input register; the state and the result register
// update when it advances, which a stalled output can delay, and the result is then offered.
// A new transaction is accepted every cycle while the output is not stalled.
// Reset clears all channel state, turns relays and alarm off and sets the
// alarm threshold to 40 degrees.
// A stall on the output holds the result; the input register then fills and
// the input stalls in turn.
`default_nettype none

module four_channel_thermostat_timer
    import fctt_pkg::*;
#(
    parameter int CHANNELS = FCTT_CHANNELS
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire fctt_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output fctt_out_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic       s1_valid_reg;
    fctt_in_t   s1_item_reg;
    logic       advance;
    logic       out_valid_reg;
    fctt_out_t  out_data_reg;
    fctt_out_t  out_data_next;
    logic [7:0] alarm_threshold_reg;

    logic [15:0] left_reg [CHANNELS];
    logic [15:0] left_next [CHANNELS];
    logic [1:0]  target_reg [CHANNELS];
    logic [1:0]  target_next [CHANNELS];
    logic [7:0]  limit_reg [CHANNELS];
    logic [7:0]  limit_next [CHANNELS];
    logic [1:0]  mode_reg [CHANNELS];
    logic [1:0]  mode_next [CHANNELS];
    logic [7:0]  hot_reg [CHANNELS];
    logic [7:0]  hot_next [CHANNELS];
    logic [7:0]  cold_reg [CHANNELS];
    logic [7:0]  cold_next [CHANNELS];

    logic [CHANNELS-1:0] relay_reg;
    logic [CHANNELS-1:0] relay_next;
    logic [CHANNELS-1:0] pend_next;
    logic [1:0]          alarm_hot_reg;
    logic [1:0]          alarm_hot_next;
    logic [2:0]          alarm_cold_reg;
    logic [2:0]          alarm_cold_next;
    logic                alarm_reg;
    logic                alarm_next;

    assign advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            alarm_threshold_reg <= ALARM_THRESHOLD_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                alarm_threshold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                left_reg[i] <= '0;
                target_reg[i] <= ACT_NONE;
                limit_reg[i] <= '0;
                mode_reg[i] <= ACT_NONE;
                hot_reg[i] <= '0;
                cold_reg[i] <= '0;
            end
            relay_reg <= '0;
            alarm_hot_reg <= '0;
            alarm_cold_reg <= '0;
            alarm_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                left_reg[i] <= left_next[i];
                target_reg[i] <= target_next[i];
                limit_reg[i] <= limit_next[i];
                mode_reg[i] <= mode_next[i];
                hot_reg[i] <= hot_next[i];
                cold_reg[i] <= cold_next[i];
            end
            relay_reg <= relay_next;
            alarm_hot_reg <= alarm_hot_next;
            alarm_cold_reg <= alarm_cold_next;
            alarm_reg <= alarm_next;
        end
    end

    always_comb
    begin
        logic [7:0]  hot_inc;
        logic [7:0]  cold_inc;
        logic        mode_valid;
        logic        sel;
        logic [MAX_CHANNELS-1:0] relay_wide;
        logic [MAX_CHANNELS-1:0] pend_wide;

        hot_inc = '0;
        cold_inc = '0;
        mode_valid = 1'b0;
        sel = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            left_next[i] = left_reg[i];
            target_next[i] = target_reg[i];
            limit_next[i] = limit_reg[i];
            mode_next[i] = mode_reg[i];
            hot_next[i] = hot_reg[i];
            cold_next[i] = cold_reg[i];
        end
        relay_next = relay_reg;
        alarm_hot_next = alarm_hot_reg;
        alarm_cold_next = alarm_cold_reg;
        alarm_next = alarm_reg;

        unique case (s1_item_reg.req_type) inside
            REQ_SAMPLE:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    hot_inc = hot_reg[i] + 8'd1;
                    cold_inc = cold_reg[i] + 8'd1;
                    mode_valid = (mode_reg[i] == ACT_OFF) || (mode_reg[i] == ACT_ON);
                    if (limit_reg[i] != 8'd0 && left_reg[i] == 16'd0)
                    begin
                        if (s1_item_reg.temp_whole > limit_reg[i] ||
                            (s1_item_reg.temp_whole == limit_reg[i] &&
                             s1_item_reg.temp_hundredths != 7'd0))
                        begin
                            cold_next[i] = '0;
                            hot_next[i] = hot_inc;
                            if (!mode_valid)
                            begin
                                if (hot_inc >= RUN_LIMIT)
                                begin
                                    hot_next[i] = '0;
                                end
                            end
                            else if (relay_reg[i] != (mode_reg[i] == ACT_ON) &&
                                     hot_inc >= RUN_LIMIT)
                            begin
                                relay_next[i] = (mode_reg[i] == ACT_ON);
                                hot_next[i] = '0;
                            end
                        end
                        else
                        begin
                            hot_next[i] = '0;
                            cold_next[i] = cold_inc;
                            if (mode_valid && relay_reg[i] == (mode_reg[i] == ACT_ON) &&
                                cold_inc >= RUN_LIMIT)
                            begin
                                relay_next[i] = (mode_reg[i] == ACT_OFF);
                                cold_next[i] = '0;
                            end
                        end
                    end
                end
                if (s1_item_reg.temp_whole >= alarm_threshold_reg)
                begin
                    alarm_hot_next = alarm_hot_reg + 2'd1;
                    alarm_cold_next = '0;
                end
                else
                begin
                    alarm_hot_next = '0;
                    alarm_cold_next = alarm_cold_reg + 3'd1;
                end
                if (alarm_hot_next == ALARM_ON_RUN)
                begin
                    alarm_next = 1'b1;
                    alarm_hot_next = '0;
                end
                else if (alarm_cold_next >= ALARM_OFF_RUN)
                begin
                    alarm_next = 1'b0;
                    alarm_cold_next = '0;
                end
            end
            REQ_TICK:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (target_reg[i] == ACT_OFF || target_reg[i] == ACT_ON)
                    begin
                        if (left_reg[i] == 16'd1)
                        begin
                            relay_next[i] = (target_reg[i] == ACT_ON);
                            left_next[i] = '0;
                            target_next[i] = ACT_NONE;
                        end
                        else
                        begin
                            left_next[i] = left_reg[i] - 16'd1;
                        end
                    end
                end
            end
            REQ_SET_TIMER, REQ_SET_THERMO, REQ_CLEAR:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    sel = (i < REPORT_CHANNELS) && (s1_item_reg.channel == 2'(i));
                    if (sel)
                    begin
                        if (s1_item_reg.req_type == REQ_SET_TIMER)
                        begin
                            left_next[i] = s1_item_reg.minutes;
                            target_next[i] = s1_item_reg.action;
                        end
                        else if (s1_item_reg.req_type == REQ_SET_THERMO)
                        begin
                            hot_next[i] = '0;
                            cold_next[i] = '0;
                            limit_next[i] = s1_item_reg.threshold;
                            mode_next[i] = s1_item_reg.action;
                        end
                        else
                        begin
                            left_next[i] = '0;
                            target_next[i] = ACT_NONE;
                            limit_next[i] = '0;
                            mode_next[i] = ACT_NONE;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < CHANNELS; i++)
        begin
            pend_next[i] = (target_next[i] == ACT_OFF) || (target_next[i] == ACT_ON);
        end
        relay_wide = MAX_CHANNELS'(relay_next);
        pend_wide = MAX_CHANNELS'(pend_next);
        out_data_next.relay_mask = relay_wide[REPORT_CHANNELS-1:0];
        out_data_next.alarm_active = alarm_next;
        out_data_next.timer_pending_mask = pend_wide[REPORT_CHANNELS-1:0];
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        alarm_hot_reg != ALARM_ON_RUN && alarm_cold_reg < ALARM_OFF_RUN)
        else $error("Alarm persistence counter passed its switching limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(relay_reg) && $stable(alarm_reg))
        else $error("Relay or alarm state changed without a transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !advance |=> !out_valid_reg)
        else $error("Result presented twice.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready) |=> $stable(alarm_threshold_reg))
        else $error("Alarm threshold changed without a write.");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for four_channel_thermostat_timer: directed corners, then thermostat,
// timer, alarm, backpressure and mixed random transactions, each status checked against a predictor.
// Depends on fctt_pkg and the four_channel_thermostat_timer module.

module testbench;
    import fctt_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int REQ_SPARE_FIRST = 5;
    localparam int REQ_SPARE_LAST = 7;
    localparam int HOLD_CYCLES = 48;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    fctt_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    fctt_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = 8'd0;

    logic [15:0] timer_count [FCTT_CHANNELS];
    logic [1:0] timer_goal [FCTT_CHANNELS];
    logic [7:0] stat_limit [FCTT_CHANNELS];
    logic [1:0] stat_mode [FCTT_CHANNELS];
    logic [7:0] warm_streak [FCTT_CHANNELS];
    logic [7:0] cool_streak [FCTT_CHANNELS];
    logic [3:0] relay_state;
    logic [1:0] alarm_warm_streak;
    logic [2:0] alarm_cool_streak;
    logic alarm_state;
    logic [7:0] alarm_level;

    fctt_out_t status_due [$];
    int mismatch_count = 0;
    int requests_sent = 0;
    int quiet_cycles = 0;
    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_request = 1'b0;

    four_channel_thermostat_timer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic fctt_out_t update_status(input fctt_in_t req);
        fctt_out_t status;
        logic warm;
        logic switching_mode;
        logic want_on;
        case (req.req_type)
            REQ_SAMPLE:
            begin
                for (int c = 0; c < FCTT_CHANNELS; c++)
                begin
                    if (stat_limit[c] != 8'd0 && timer_count[c] == 16'd0)
                    begin
                        warm = req.temp_whole > stat_limit[c] ||
                               (req.temp_whole == stat_limit[c] && req.temp_hundredths != 7'd0);
                        switching_mode = stat_mode[c] == ACT_OFF || stat_mode[c] == ACT_ON;
                        want_on = stat_mode[c] == ACT_ON;
                        if (warm)
                        begin
                            warm_streak[c] = warm_streak[c] + 8'd1;
                            cool_streak[c] = 8'd0;
                            if (warm_streak[c] >= RUN_LIMIT &&
                                (!switching_mode || relay_state[c] != want_on))
                            begin
                                if (switching_mode)
                                    relay_state[c] = want_on;
                                warm_streak[c] = 8'd0;
                            end
                        end
                        else
                        begin
                            cool_streak[c] = cool_streak[c] + 8'd1;
                            warm_streak[c] = 8'd0;
                            if (switching_mode && relay_state[c] == want_on &&
                                cool_streak[c] >= RUN_LIMIT)
                            begin
                                relay_state[c] = !want_on;
                                cool_streak[c] = 8'd0;
                            end
                        end
                    end
                end
                if (req.temp_whole >= alarm_level)
                begin
                    alarm_warm_streak = alarm_warm_streak + 2'd1;
                    alarm_cool_streak = 3'd0;
                end
                else
                begin
                    alarm_cool_streak = alarm_cool_streak + 3'd1;
                    alarm_warm_streak = 2'd0;
                end
                if (alarm_warm_streak == ALARM_ON_RUN)
                begin
                    alarm_state = 1'b1;
                    alarm_warm_streak = 2'd0;
                end
                else if (alarm_cool_streak >= ALARM_OFF_RUN)
                begin
                    alarm_state = 1'b0;
                    alarm_cool_streak = 3'd0;
                end
            end
            REQ_TICK:
            begin
                for (int c = 0; c < FCTT_CHANNELS; c++)
                begin
                    if (timer_goal[c] == ACT_OFF || timer_goal[c] == ACT_ON)
                    begin
                        if (timer_count[c] == 16'd1)
                        begin
                            relay_state[c] = timer_goal[c] == ACT_ON;
                            timer_count[c] = 16'd0;
                            timer_goal[c] = ACT_NONE;
                        end
                        else
                            timer_count[c] = timer_count[c] - 16'd1;
                    end
                end
            end
            REQ_SET_TIMER:
            begin
                timer_count[req.channel] = req.minutes;
                timer_goal[req.channel] = req.action;
            end
            REQ_SET_THERMO:
            begin
                warm_streak[req.channel] = 8'd0;
                cool_streak[req.channel] = 8'd0;
                stat_limit[req.channel] = req.threshold;
                stat_mode[req.channel] = req.action;
            end
            REQ_CLEAR:
            begin
                timer_count[req.channel] = 16'd0;
                timer_goal[req.channel] = ACT_NONE;
                stat_limit[req.channel] = 8'd0;
                stat_mode[req.channel] = ACT_NONE;
            end
            default: ;
        endcase
        status.relay_mask = relay_state;
        status.alarm_active = alarm_state;
        for (int c = 0; c < FCTT_CHANNELS; c++)
            status.timer_pending_mask[c] = timer_goal[c] == ACT_OFF || timer_goal[c] == ACT_ON;
        return status;
    endfunction

    always @(posedge clk)
    begin : monitor
        fctt_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    $error("unexpected transaction: relay_mask %h alarm_active %h pending %h",
                           out_data.relay_mask, out_data.alarm_active,
                           out_data.timer_pending_mask);
                    mismatch_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (out_data.relay_mask !== want.relay_mask)
                    begin
                        $error("relay_mask: expected %h, got %h",
                               want.relay_mask, out_data.relay_mask);
                        mismatch_count++;
                    end
                    if (out_data.alarm_active !== want.alarm_active)
                    begin
                        $error("alarm_active: expected %h, got %h",
                               want.alarm_active, out_data.alarm_active);
                        mismatch_count++;
                    end
                    if (out_data.timer_pending_mask !== want.timer_pending_mask)
                    begin
                        $error("timer_pending_mask: expected %h, got %h",
                               want.timer_pending_mask, out_data.timer_pending_mask);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                status_due.push_back(update_status(in_data));
            if (cfg_valid && cfg_ready)
                alarm_level = cfg_data;
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic fctt_in_t random_fields();
        fctt_in_t r;
        r.req_type = 3'($urandom_range(0, 7));
        r.channel = 2'($urandom_range(0, 3));
        r.temp_whole = 8'($urandom_range(0, 255));
        r.temp_hundredths = 7'($urandom_range(0, 99));
        r.minutes = 16'($urandom);
        r.action = 2'($urandom_range(0, 3));
        r.threshold = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic logic [7:0] clamp_temp(input int t);
        if (t < 0)
            return 8'd0;
        if (t > 255)
            return 8'd255;
        return 8'(t);
    endfunction

    task automatic send_request(input fctt_in_t req);
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        requests_sent++;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (status_due.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_alarm_threshold(input logic [7:0] level);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= level;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [7:0] whole, input logic [6:0] hund);
        fctt_in_t r;
        r = random_fields();
        r.req_type = REQ_SAMPLE;
        r.temp_whole = whole;
        r.temp_hundredths = hund;
        send_request(r);
    endtask

    task automatic send_tick();
        fctt_in_t r;
        r = random_fields();
        r.req_type = REQ_TICK;
        send_request(r);
    endtask

    task automatic send_timer(input logic [1:0] ch, input logic [15:0] mins,
                              input logic [1:0] act);
        fctt_in_t r;
        r = random_fields();
        r.req_type = REQ_SET_TIMER;
        r.channel = ch;
        r.minutes = mins;
        r.action = act;
        send_request(r);
    endtask

    task automatic send_thermostat(input logic [1:0] ch, input logic [7:0] limit,
                                   input logic [1:0] act);
        fctt_in_t r;
        r = random_fields();
        r.req_type = REQ_SET_THERMO;
        r.channel = ch;
        r.threshold = limit;
        r.action = act;
        send_request(r);
    endtask

    task automatic send_clear(input logic [1:0] ch);
        fctt_in_t r;
        r = random_fields();
        r.req_type = REQ_CLEAR;
        r.channel = ch;
        send_request(r);
    endtask

    // A sample on the warm or cool side of a limit; now and then it lands on the other side.
    task automatic send_near(input logic [7:0] limit, input bit warm);
        int offset;
        logic [6:0] hund;
        offset = int'($urandom_range(0, 3));
        hund = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(1, 99));
        send_sample(clamp_temp(warm ? int'(limit) + offset : int'(limit) - offset), hund);
    endtask

    task automatic test_directed_corners();
        fctt_in_t r;
        send_sample(8'd255, 7'd99);
        send_sample(8'd0, 7'd0);
        send_sample(ALARM_THRESHOLD_RESET, 7'd0);
        send_sample(ALARM_THRESHOLD_RESET, 7'd0);
        send_tick();
        send_timer(2'd0, 16'd1, ACT_ON);
        send_tick();
        send_timer(2'd1, 16'd0, ACT_OFF);
        send_tick();
        send_timer(2'd2, 16'hFFFF, ACT_SPARE);
        send_thermostat(2'd2, 8'd255, ACT_ON);
        send_sample(8'd255, 7'd1);
        send_clear(2'd1);
        send_clear(2'd2);
        send_thermostat(2'd3, 8'd1, ACT_SPARE);
        send_thermostat(2'd3, 8'd0, ACT_OFF);
        send_timer(2'd3, 16'd2, ACT_NONE);
        for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
        begin
            r = random_fields();
            r.req_type = 3'(k);
            send_request(r);
        end
        repeat (5) send_sample(8'd0, 7'd50);
        wait_for_results();
    endtask

    task automatic test_thermostat_runs(input int count);
        int stop_at;
        int pick;
        logic [1:0] ch;
        logic [7:0] limit;
        logic [1:0] mode;
        bit warm;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            ch = 2'($urandom_range(0, 3));
            limit = 8'($urandom_range(1, 255));
            pick = int'($urandom_range(0, 9));
            mode = pick < 4 ? ACT_ON : pick < 8 ? ACT_OFF : pick == 8 ? ACT_NONE : ACT_SPARE;
            if ($urandom_range(0, 3) == 0)
                send_clear(ch);
            send_thermostat(ch, limit, mode);
            repeat ($urandom_range(2, 5))
            begin
                warm = 1'($urandom_range(0, 1));
                repeat ($urandom_range(8, 16))
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_tick();
                    else
                        send_near(limit, warm);
                end
            end
        end
        wait_for_results();
    endtask

    task automatic test_timer_countdowns(input int count);
        int stop_at;
        int pick;
        logic [1:0] ch;
        logic [15:0] mins;
        logic [1:0] act;
        logic [7:0] limit;
        stop_at = requests_sent + count;
        limit = 8'($urandom_range(1, 255));
        while (requests_sent < stop_at)
        begin
            ch = 2'($urandom_range(0, 3));
            pick = int'($urandom_range(0, 9));
            mins = pick < 7 ? 16'($urandom_range(1, 6)) : pick == 7 ? 16'd0 :
                   pick == 8 ? 16'($urandom) : 16'($urandom_range(7, 40));
            if ($urandom_range(0, 9) < 8)
                act = $urandom_range(0, 1) ? ACT_ON : ACT_OFF;
            else
                act = $urandom_range(0, 1) ? ACT_NONE : ACT_SPARE;
            send_timer(ch, mins, act);
            if ($urandom_range(0, 3) == 0)
            begin
                limit = 8'($urandom_range(1, 255));
                send_thermostat(ch, limit, $urandom_range(0, 1) ? ACT_ON : ACT_OFF);
            end
            repeat ($urandom_range(1, 8))
            begin
                pick = int'($urandom_range(0, 5));
                if (pick < 4)
                    send_tick();
                else if (pick == 4)
                    send_near(limit, 1'($urandom_range(0, 1)));
                else
                    send_clear(2'($urandom_range(0, 3)));
            end
        end
        wait_for_results();
    endtask

    task automatic test_alarm_thresholds();
        logic [7:0] levels [6];
        int stop_at;
        bit above;
        levels = '{8'd0, 8'd255, ALARM_THRESHOLD_RESET, 8'd1, 8'd254, 8'd0};
        levels[5] = 8'($urandom_range(0, 255));
        foreach (levels[k])
        begin
            write_alarm_threshold(levels[k]);
            stop_at = requests_sent + 50;
            while (requests_sent < stop_at)
            begin
                above = 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_tick();
                    else if (above)
                        send_sample(clamp_temp(int'(levels[k]) + int'($urandom_range(0, 2))),
                                    7'($urandom_range(0, 99)));
                    else
                        send_sample(clamp_temp(int'(levels[k]) - int'($urandom_range(1, 2))),
                                    7'($urandom_range(0, 99)));
                end
            end
        end
        wait_for_results();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        hold_request = 1'b1;
        repeat (30) send_request(random_fields());
        wait_for_results();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_random_mix(input int count);
        int stop_at;
        int quiet_from;
        int pause_at;
        int pick;
        logic [7:0] focus;
        fctt_in_t r;
        write_alarm_threshold(8'($urandom_range(0, 255)));
        stop_at = requests_sent + count;
        quiet_from = stop_at - count / 3;
        pause_at = requests_sent + count / 3;
        focus = 8'($urandom_range(1, 255));
        while (requests_sent < stop_at)
        begin
            if (requests_sent == pause_at)
                write_alarm_threshold(8'($urandom_range(0, 255)));
            if (requests_sent >= quiet_from)
            begin
                sender_gaps = 1'b0;
                receiver_gaps = 1'b0;
            end
            r = random_fields();
            pick = int'($urandom_range(0, 19));
            if (pick < 9)
            begin
                r.req_type = REQ_SAMPLE;
                if ($urandom_range(0, 1))
                    r.temp_whole = clamp_temp(int'(focus) + int'($urandom_range(0, 6)) - 3);
            end
            else if (pick < 13)
                r.req_type = REQ_TICK;
            else if (pick < 15)
            begin
                r.req_type = REQ_SET_TIMER;
                if ($urandom_range(0, 1))
                    r.minutes = 16'($urandom_range(0, 8));
            end
            else if (pick < 17)
            begin
                r.req_type = REQ_SET_THERMO;
                if ($urandom_range(0, 1))
                    r.threshold = focus;
            end
            else if (pick < 18)
                r.req_type = REQ_CLEAR;
            if ($urandom_range(0, 63) == 0)
                focus = 8'($urandom_range(1, 255));
            send_request(r);
        end
        wait_for_results();
    endtask

    initial
    begin
        for (int c = 0; c < FCTT_CHANNELS; c++)
        begin
            timer_count[c] = 16'd0;
            timer_goal[c] = ACT_NONE;
            stat_limit[c] = 8'd0;
            stat_mode[c] = ACT_NONE;
            warm_streak[c] = 8'd0;
            cool_streak[c] = 8'd0;
        end
        relay_state = 4'd0;
        alarm_warm_streak = 2'd0;
        alarm_cool_streak = 3'd0;
        alarm_state = 1'b0;
        alarm_level = ALARM_THRESHOLD_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_thermostat_runs(440);
        test_timer_countdowns(300);
        test_alarm_thresholds();
        test_backpressure();
        test_random_mix(480);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fctt_pkg.sv
sv/four_channel_thermostat_timer.sv
tb/testbench.sv
